// ===== rtl/mctq_pkg.sv =====
// Shared types, constants and helpers for the multi-channel timer queue.
package mctq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int COUNT_WIDTH = 32;

    // Only the first sixteen timers can be addressed or shown in the mask.
    localparam int NUM_LIVE = (TIMER_SLOTS < 16) ? TIMER_SLOTS : 16;
    localparam int LIVE_AW  = (NUM_LIVE > 1) ? $clog2(NUM_LIVE) : 1;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [1:0] EV_EXPIRED = 2'd0;
    localparam logic [1:0] EV_STARTED = 2'd1;
    localparam logic [1:0] EV_STOPPED = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  timer_index;
        logic [31:0] timeout;
        logic        periodic;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [3:0]  event_timer;
        logic [15:0] running_mask;
        logic        last;
    } t_out_item;

    // Clamp a requested timeout into the counter range, raising zero to one.
    function automatic logic [COUNT_WIDTH-1:0] sat_timeout(input logic [31:0] v);
        logic [63:0] t;
        logic [63:0] cmax;
        t    = {32'd0, v};
        cmax = {64{1'b1}} >> (64 - COUNT_WIDTH);
        if (t > cmax) begin
            t = cmax;
        end
        if (t == 64'd0) begin
            t = 64'd1;
        end
        return t[COUNT_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/multi_channel_timer_queue_core.sv =====
// Top level of the multi-channel timer queue: counter memories, scan and result emit.
//
// Start and stop each give one acknowledge item carrying the running mask
// after the update. A tick sweeps the countdown memory once, one timer per
// cycle through its single read port with a registered read; expiry items then
// leave one per cycle while the output is free, in ascending timer order, the
// last one flagged. A tick with no expiry gives no item. The next input item is
// taken once the block is back in idle and the output register is free or being
// emptied.
module multi_channel_timer_queue_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mctq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mctq_pkg::t_out_item o_out_item
);
    import mctq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    localparam logic [LIVE_AW-1:0] LAST_IDX = LIVE_AW'(NUM_LIVE - 1);

    // Countdown and reload memories
    logic [COUNT_WIDTH-1:0] mem_rem [NUM_LIVE];
    logic [COUNT_WIDTH-1:0] mem_rel [NUM_LIVE];
    logic [COUNT_WIDTH-1:0] r_rem_rd;
    logic [COUNT_WIDTH-1:0] r_rel_rd;

    t_state              r_state,    n_state;
    logic [NUM_LIVE-1:0] r_armed,    n_armed;
    logic [NUM_LIVE-1:0] r_periodic, n_periodic;
    logic [NUM_LIVE-1:0] r_hits,     n_hits;
    logic [LIVE_AW-1:0]  r_rd_cnt,   n_rd_cnt;
    logic                r_issuing,  n_issuing;
    logic                r_pv,       n_pv;
    logic [LIVE_AW-1:0]  r_pidx,     n_pidx;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out,      n_out;

    logic                   w_rd_en;
    logic                   w_rem_we;
    logic                   w_rel_we;
    logic [LIVE_AW-1:0]     w_addr;
    logic [COUNT_WIDTH-1:0] w_rem_data;
    logic [COUNT_WIDTH-1:0] w_rel_data;
    logic                   w_out_free;
    logic                   w_accept;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    function automatic logic [15:0] mask16(input logic [NUM_LIVE-1:0] a);
        logic [15:0] m;
        m = '0;
        m[NUM_LIVE-1:0] = a;
        return m;
    endfunction

    always_comb begin
        logic                   in_range;
        logic [LIVE_AW-1:0]     idx;
        logic [COUNT_WIDTH-1:0] t_sat;
        logic                   expire;
        logic [LIVE_AW-1:0]     sel;
        logic [NUM_LIVE-1:0]    rest;

        n_state     = r_state;
        n_armed     = r_armed;
        n_periodic  = r_periodic;
        n_hits      = r_hits;
        n_rd_cnt    = r_rd_cnt;
        n_issuing   = r_issuing;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        w_rd_en    = 1'b0;
        w_rem_we   = 1'b0;
        w_rel_we   = 1'b0;
        w_addr     = r_rd_cnt;
        w_rem_data = r_rel_rd;
        w_rel_data = r_rel_rd;

        in_range = (5'(i_in_item.timer_index) < 5'(NUM_LIVE));
        idx      = i_in_item.timer_index[LIVE_AW-1:0];
        t_sat    = sat_timeout(i_in_item.timeout);
        expire   = (r_rem_rd <= COUNT_WIDTH'(1));
        sel      = '0;
        for (int i = NUM_LIVE - 1; i >= 0; i--) begin
            if (r_hits[i]) begin
                sel = LIVE_AW'(i);
            end
        end
        rest      = r_hits;
        rest[sel] = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.opcode == OP_TICK) begin
                        n_state   = S_SCAN;
                        n_rd_cnt  = '0;
                        n_issuing = 1'b1;
                        n_hits    = '0;
                    end else if (i_in_item.opcode == OP_START) begin
                        if (in_range) begin
                            w_addr          = idx;
                            w_rem_we        = 1'b1;
                            w_rel_we        = 1'b1;
                            w_rem_data      = t_sat;
                            w_rel_data      = t_sat;
                            n_armed[idx]    = 1'b1;
                            n_periodic[idx] = i_in_item.periodic;
                        end
                        n_out_valid        = 1'b1;
                        n_out.event_kind   = EV_STARTED;
                        n_out.event_timer  = i_in_item.timer_index;
                        n_out.running_mask = mask16(n_armed);
                        n_out.last         = 1'b1;
                    end else if (i_in_item.opcode == OP_STOP) begin
                        if (in_range) begin
                            n_armed[idx] = 1'b0;
                        end
                        n_out_valid        = 1'b1;
                        n_out.event_kind   = EV_STOPPED;
                        n_out.event_timer  = i_in_item.timer_index;
                        n_out.running_mask = mask16(n_armed);
                        n_out.last         = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // Issue the read of the next entry while the previous one is updated.
                if (r_issuing) begin
                    w_rd_en = 1'b1;
                    n_pv    = 1'b1;
                    n_pidx  = r_rd_cnt;
                    if (r_rd_cnt == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_rd_cnt = r_rd_cnt + LIVE_AW'(1);
                    end
                end
                if (r_pv) begin
                    w_addr = r_pidx;
                    if (r_armed[r_pidx]) begin
                        if (!expire) begin
                            w_rem_we   = 1'b1;
                            w_rem_data = r_rem_rd - COUNT_WIDTH'(1);
                        end else begin
                            n_hits[r_pidx] = 1'b1;
                            if (r_periodic[r_pidx]) begin
                                w_rem_we   = 1'b1;
                                w_rem_data = r_rel_rd;
                            end else begin
                                n_armed[r_pidx] = 1'b0;
                            end
                        end
                    end
                    if (r_pidx == LAST_IDX) begin
                        n_state = (n_hits != '0) ? S_EMIT : S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.event_kind   = EV_EXPIRED;
                    n_out.event_timer  = 4'(sel);
                    n_out.running_mask = mask16(r_armed);
                    n_out.last         = (rest == '0);
                    n_hits             = rest;
                    if (rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rem_rd <= mem_rem[r_rd_cnt];
            r_rel_rd <= mem_rel[r_rd_cnt];
        end
        if (w_rem_we) begin
            mem_rem[w_addr] <= w_rem_data;
        end
        if (w_rel_we) begin
            mem_rel[w_addr] <= w_rel_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= '0;
            r_periodic  <= '0;
            r_hits      <= '0;
            r_rd_cnt    <= '0;
            r_issuing   <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_armed     <= n_armed;
            r_periodic  <= n_periodic;
            r_hits      <= n_hits;
            r_rd_cnt    <= n_rd_cnt;
            r_issuing   <= n_issuing;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
        r_pidx <= n_pidx;
        r_out  <= n_out;
    end

endmodule

// ===== tb/sv/multi_channel_timer_queue_core_tb.sv =====
// Self-checking testbench for the multi-channel timer queue core.
module multi_channel_timer_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mctq_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    multi_channel_timer_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // Timer bank as the block should hold it.
    logic [COUNT_WIDTH-1:0] timer_left   [NUM_LIVE];
    logic [COUNT_WIDTH-1:0] timer_reload [NUM_LIVE];
    logic [NUM_LIVE-1:0]    timer_periodic = '0;
    logic [NUM_LIVE-1:0]    timer_armed    = '0;

    t_out_item pending_events[$];

    int unsigned mismatches      = 0;
    int unsigned items_sent      = 0;
    int unsigned events_checked  = 0;
    int unsigned expiries_seen   = 0;
    int unsigned ready_hold      = 0;
    bit          steady          = 1'b0;
    t_out_item   want;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        if (mismatches < 40) begin
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, exp_v);
        end
        mismatches++;
    endtask

    // Advance the timer bank by one accepted item and queue the events it causes.
    task automatic predict_events(input t_in_item it);
        logic [3:0]             hits[$];
        t_out_item              ev;
        logic [COUNT_WIDTH-1:0] load;
        case (it.opcode)
            OP_TICK: begin
                for (int i = 0; i < NUM_LIVE; i++) begin
                    if (timer_armed[i]) begin
                        if (timer_left[i] > 1) begin
                            timer_left[i] = timer_left[i] - 1'b1;
                        end else begin
                            hits.push_back(4'(i));
                            if (timer_periodic[i]) begin
                                timer_left[i] = timer_reload[i];
                            end else begin
                                timer_left[i]  = '0;
                                timer_armed[i] = 1'b0;
                            end
                        end
                    end
                end
                foreach (hits[k]) begin
                    ev.event_kind   = EV_EXPIRED;
                    ev.event_timer  = hits[k];
                    ev.running_mask = 16'(timer_armed);
                    ev.last         = (k == hits.size() - 1);
                    pending_events.push_back(ev);
                end
            end
            OP_START: begin
                // Saturate to the counter range and raise zero to one.
                load = sat_timeout(it.timeout);
                if (it.timer_index < NUM_LIVE) begin
                    timer_reload[it.timer_index]   = load;
                    timer_left[it.timer_index]     = load;
                    timer_periodic[it.timer_index] = it.periodic;
                    timer_armed[it.timer_index]    = 1'b1;
                end
                ev.event_kind   = EV_STARTED;
                ev.event_timer  = it.timer_index;
                ev.running_mask = 16'(timer_armed);
                ev.last         = 1'b1;
                pending_events.push_back(ev);
            end
            OP_STOP: begin
                if (it.timer_index < NUM_LIVE) begin
                    timer_armed[it.timer_index] = 1'b0;
                end
                ev.event_kind   = EV_STOPPED;
                ev.event_timer  = it.timer_index;
                ev.running_mask = 16'(timer_armed);
                ev.last         = 1'b1;
                pending_events.push_back(ev);
            end
            default: begin
            end
        endcase
    endtask

    // Present one item, hold it until accepted, then idle for a random gap, which may be zero.
    task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                             input logic [31:0] tmo, input logic per);
        t_in_item    it;
        int unsigned gap;
        it.opcode      = op;
        it.timer_index = idx;
        it.timeout     = tmo;
        it.periodic    = per;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && o_in_ready));
        predict_events(it);
        items_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every queued event, then let any sweep in flight finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_ack_and_edges();
        send_item(OP_START, 4'd0, 32'd0, 1'b0);         // zero timeout acts as one
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_item(OP_START, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_STOP, 4'd15, 32'd0, 1'b0);
        send_item(OP_STOP, 4'd3, 32'hFFFF_FFFF, 1'b1);  // idle timer, still acked
        send_item(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1); // nothing armed, no event
        settle();
    endtask

    task automatic test_restart_and_reload();
        send_item(OP_START, 4'd5, 32'd2, 1'b1);
        send_item(OP_START, 4'd9, 32'd0, 1'b0);
        send_item(OP_START, 4'd5, 32'd3, 1'b1);         // restart discards old count
        repeat (3) send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_item(OP_STOP, 4'd5, 32'd0, 1'b0);
        settle();
    endtask

    task automatic test_all_expire();
        for (int i = 0; i < NUM_LIVE; i++) begin
            send_item(OP_START, 4'(i), 32'd1, 1'b0);
        end
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        settle();
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned chunk);
        int unsigned done;
        int unsigned r;
        logic [31:0] tmo;
        done = 0;
        while (done < count) begin
            r   = $urandom_range(0, 99);
            tmo = ($urandom_range(0, 19) == 0) ? $urandom() : 32'($urandom_range(0, 5));
            if (r < 45) begin
                send_item(OP_TICK, 4'($urandom()), $urandom(), 1'($urandom()));
                done++;
            end else if (r < 80) begin
                send_item(OP_START, 4'($urandom()), tmo, 1'($urandom()));
                done++;
            end else if (r < 95) begin
                send_item(OP_STOP, 4'($urandom()), $urandom(), 1'($urandom()));
                done++;
            end else begin
                send_item(OP_UNUSED, 4'($urandom()), $urandom(), 1'($urandom()));
            end
            // When chunk is nonzero, hold the sender every chunk counted items until the block has drained.
            if (chunk != 0 && done != 0 && done % chunk == 0) begin
                settle();
            end
        end
        settle();
    endtask

    // Downstream ready: random stretches high and low, or held high in steady mode.
    always @(posedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold != 0) begin
            ready_hold--;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
            ready_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected item", o_out_item, 0);
            end else begin
                want = pending_events.pop_front();
                if (o_out_item.event_kind != want.event_kind) begin
                    report_mismatch("event_kind", o_out_item.event_kind, want.event_kind);
                end
                if (o_out_item.event_timer != want.event_timer) begin
                    report_mismatch("event_timer", o_out_item.event_timer, want.event_timer);
                end
                if (o_out_item.running_mask != want.running_mask) begin
                    report_mismatch("running_mask", o_out_item.running_mask,
                                    want.running_mask);
                end
                if (o_out_item.last != want.last) begin
                    report_mismatch("last", o_out_item.last, want.last);
                end
                if (want.event_kind == EV_EXPIRED) begin
                    expiries_seen++;
                end
            end
            events_checked++;
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ack_and_edges();
        test_restart_and_reload();
        test_all_expire();
        steady = 1'b1;
        test_random_traffic(60, 0);
        steady = 1'b0;
        test_random_traffic(240, 60);

        settle();
        if (pending_events.size() != 0) begin
            report_mismatch("events never delivered", pending_events.size(), 0);
        end
        $display("covered %0d accepted items and %0d result items, %0d of them expiries",
                 items_sent, events_checked, expiries_seen);
        $display("start, stop, tick, unused opcode, restart, reload and full-bank expiry");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
